[design/mmm_pkg.sv]
`default_nettype none

package mmm_pkg;

	typedef enum logic [2:0] {
		S_LOAD = 3'b001,
		S_KICK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	// Control broadcast to every cell of the sort chain.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

[design/mmm_if.sv]
`default_nettype none

interface mmm_in_if #(
	parameter int W = 32
);
	logic         valid;
	logic         ready;
	logic [W-1:0] sample;
	logic         last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface mmm_out_if #(
	parameter int W = 32
);
	logic         valid;
	logic         ready;
	logic [W-1:0] score;
	logic         overflowed;

	modport source (output valid, output score, output overflowed, input ready);
	modport sink (input valid, input score, input overflowed, output ready);
endinterface

`default_nettype wire

[design/mmm_cell.sv]
`default_nettype none

module mmm_cell import mmm_pkg::*; #(
	parameter int W   = 32,
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [CW-1:0]       count,
	input  logic signed [W-1:0] din,
	input  logic signed [W-1:0] prev_val,
	input  logic                prev_gt,
	input  logic signed [W-1:0] next_val,
	output logic signed [W-1:0] val,
	output logic                gt
);

	logic signed [W-1:0] val_q;
	logic                occ;

	assign occ = count > CW'(IDX);
	assign gt  = occ && (val_q > din);
	assign val = val_q;

	// Insert: an occupied cell above the new sample moves right; the first such
	// cell (or the first empty one) takes the sample. Shift drains toward cell 0.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= next_val;
		end else if (ctl.load && (!occ || gt)) begin
			val_q <= prev_gt ? prev_val : din;
		end
	end

endmodule

`default_nettype wire

[design/mmm_div.sv]
`default_nettype none

module mmm_div #(
	parameter int NW = 37,
	parameter int DW = 5,
	parameter int QW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] dividend,
	input  logic [DW-1:0]        divisor,
	output logic                 done,
	output logic signed [QW-1:0] quotient
);

	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] a_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [KW-1:0] cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          qbit;
	logic [DW:0]   r_next;
	logic [NW-1:0] q_signed;

	assign trial    = {r_q, a_q[NW-1]};
	assign qbit     = trial >= {1'b0, d_q};
	assign r_next   = qbit ? (trial - {1'b0, d_q}) : trial;
	assign q_signed = neg_q ? (~a_q + NW'(1)) : a_q;
	assign quotient = q_signed[QW-1:0];
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - KW'(1);
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Restoring divide on the magnitude, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= dividend[NW-1] ? (~dividend + NW'(1)) : dividend;
			neg_q <= dividend[NW-1];
			r_q   <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			a_q <= {a_q[NW-2:0], qbit};
			r_q <= r_next[DW-1:0];
		end
	end

endmodule

`default_nettype wire

[design/min_of_median_and_mean.sv]
// Loading: one sample per cycle, inserted into a sorted chain of MAX_SAMPLES cells.
// Closing a set: the marked transaction, then the start state, then the bit-serial
// divider over SAMPLE_WIDTH + clog2(MAX_SAMPLES+1) bits (37 at default), then the
// result registered once the output is free; no samples are taken meanwhile.
// The result register frees the input side while a score waits to be taken.
// Reset (arst_n low) clears count, sum, overflow flag, FSM and result valid.
`default_nettype none

module min_of_median_and_mean import mmm_pkg::*; #(
	parameter int MAX_SAMPLES  = 16,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	mmm_in_if.sink   samples,
	mmm_out_if.source result
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SW + CW;
	localparam int N1   = (MAX_SAMPLES > 1) ? 1 : 0;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic signed [SUMW-1:0] sum_q;
	logic                   ovf_q;
	logic [CW-1:0]          sh_q;
	logic                   med_done_q;
	logic signed [SW-1:0]   med_q;
	logic                   res_valid_q;
	logic signed [SW-1:0]   score_q;
	logic                   res_ovf_q;

	logic                   acc;
	logic                   full;
	logic [CW-1:0]          target;
	logic                   at_target;
	logic signed [SW:0]     pair_sum;
	logic signed [SW-1:0]   med_val;
	logic                   div_done;
	logic signed [SW-1:0]   mean;
	logic                   fin_ok;
	cell_ctl_t              ctl;

	logic signed [SW-1:0]   cval [MAX_SAMPLES];
	logic                   cgt  [MAX_SAMPLES];

	assign acc     = samples.valid && samples.ready;
	assign full    = count_q == CW'(MAX_SAMPLES);
	assign samples.ready = state_q == S_LOAD;

	// Drain to the lower middle in cell 0; an even count puts the upper one in cell 1.
	assign target    = count_q[0] ? (count_q >> 1) : ((count_q >> 1) - CW'(1));
	assign at_target = sh_q == target;
	assign pair_sum  = {cval[0][SW-1], cval[0]} + {cval[N1][SW-1], cval[N1]};
	assign med_val   = count_q[0] ? cval[0] : pair_sum[SW:1];

	assign ctl.load  = acc && !full;
	assign ctl.shift = (state_q == S_FIN) && !med_done_q && !at_target;

	assign fin_ok = (state_q == S_FIN) && med_done_q && div_done
		&& (!res_valid_q || result.ready);

	genvar gi;
	generate
		for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
			mmm_cell #(
				.W   (SW),
				.CW  (CW),
				.IDX (gi)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.count    (count_q),
				.din      (samples.sample),
				.prev_val ((gi == 0) ? cval[0] : cval[(gi == 0) ? 0 : gi - 1]),
				.prev_gt  ((gi == 0) ? 1'b0 : cgt[(gi == 0) ? 0 : gi - 1]),
				.next_val (cval[(gi == MAX_SAMPLES - 1) ? gi : gi + 1]),
				.val      (cval[gi]),
				.gt       (cgt[gi])
			);
		end
	endgenerate

	mmm_div #(
		.NW (SUMW),
		.DW (CW),
		.QW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_KICK),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			sh_q        <= '0;
			med_done_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fin_ok) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
							sum_q   <= sum_q + {{CW{samples.sample[SW-1]}}, samples.sample};
						end
						if (samples.last) begin
							state_q <= S_KICK;
						end
					end
				end
				S_KICK: begin
					sh_q       <= '0;
					med_done_q <= 1'b0;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (!med_done_q) begin
						if (at_target) begin
							med_done_q <= 1'b1;
						end else begin
							sh_q <= sh_q + CW'(1);
						end
					end
					if (fin_ok) begin
						count_q     <= '0;
						sum_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && !med_done_q && at_target) begin
			med_q <= med_val;
		end
		if (fin_ok) begin
			score_q   <= (mean < med_q) ? mean : med_q;
			res_ovf_q <= ovf_q;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.score      = score_q;
	assign result.overflowed = res_ovf_q;

endmodule

`default_nettype wire

[tb/sv/min_of_median_and_mean_chk.sv]
`default_nettype none

module min_of_median_and_mean_chk #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic clk,
	input  logic arst_n,
	mmm_in_if    in_ch,
	mmm_out_if   out_ch,
	output int   fails,
	output int   waiting,
	output int   n_scored,
	output int   n_overflow
);

	typedef struct {
		logic [31:0] score;
		logic        overflowed;
	} score_t;

	score_t  pending_scores[$];

	// Predictor state for the set being collected
	longint  held[MAX_SAMPLES];
	int      n_held;
	longint  total;
	bit      dropped;

	task automatic fold_sample(input logic [31:0] raw, input logic is_last);
		longint v;
		longint med;
		longint avg;
		int     pos;
		int     half;
		score_t s;
		v = longint'($signed(raw));
		if (n_held < MAX_SAMPLES) begin
			pos = n_held;
			while (pos > 0 && held[pos-1] > v) begin
				held[pos] = held[pos-1];
				pos--;
			end
			held[pos] = v;
			n_held++;
			total += v;
		end else begin
			dropped = 1'b1;
		end
		if (is_last) begin
			half = n_held / 2;
			if (n_held % 2 != 0)
				med = held[half];
			else
				med = (held[half] + held[half-1]) >>> 1;
			// longint division truncates toward zero
			avg = total / longint'(n_held);
			s.score      = (avg < med) ? avg[31:0] : med[31:0];
			s.overflowed = dropped;
			pending_scores.insert(pending_scores.size(), s);
			if (dropped)
				n_overflow++;
			n_held  = 0;
			total   = 0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		score_t exp_s;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				fold_sample(in_ch.sample, in_ch.last);
			if (out_ch.valid && out_ch.ready) begin
				if (pending_scores.size() == 0) begin
					$display("%0t: unexpected result score %h overflowed %b", $time,
						out_ch.score, out_ch.overflowed);
					fails++;
				end else begin
					exp_s = pending_scores.pop_front();
					n_scored++;
					if (out_ch.score !== exp_s.score) begin
						$display("%0t: score mismatch, expected %h got %h", $time,
							exp_s.score, out_ch.score);
						fails++;
					end
					if (out_ch.overflowed !== exp_s.overflowed) begin
						$display("%0t: overflowed mismatch, expected %b got %b", $time,
							exp_s.overflowed, out_ch.overflowed);
						fails++;
					end
				end
			end
			waiting = pending_scores.size();
		end
	end

endmodule

`default_nettype wire

[tb/sv/min_of_median_and_mean_tb.sv]
`default_nettype none

module min_of_median_and_mean_tb;

	localparam int MAX_SAMPLES = 16;
	localparam int SW          = 32;

	logic clk;
	logic arst_n;

	int   tx_idle_pct;
	int   rx_idle_pct;
	int   n_items;
	int   n_sets;
	int   fails;
	int   waiting;
	int   n_scored;
	int   n_overflow;

	mmm_in_if  #(.W(SW)) in_ch ();
	mmm_out_if #(.W(SW)) out_ch ();

	min_of_median_and_mean #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.result(out_ch)
	);

	min_of_median_and_mean_chk #(.MAX_SAMPLES(MAX_SAMPLES)) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.fails     (fails),
		.waiting   (waiting),
		.n_scored  (n_scored),
		.n_overflow(n_overflow)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	// One transaction on the sample channel; returns at the falling edge after it
	task automatic offer_sample(input logic [31:0] s, input logic is_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.sample <= $urandom;
			in_ch.last <= 1'($urandom_range(1));
			@(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.sample <= s;
		in_ch.last   <= is_last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		n_items++;
		if (is_last)
			n_sets++;
	endtask

	task automatic drain_scores();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (waiting != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(131072)) - 32'd65536;
			3: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int set_len;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		in_ch.last   = 1'b0;
		tx_idle_pct  = 36;
		rx_idle_pct  = 52;
		n_items      = 0;
		n_sets       = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-sample sets at the extremes
		offer_sample(32'h7fff_ffff, 1'b1);
		offer_sample(32'h8000_0000, 1'b1);
		offer_sample(32'h0000_0000, 1'b1);
		// even count with odd negative middle sum: median floors, mean truncates
		offer_sample(32'hffff_fffd, 1'b0);
		offer_sample(32'h0000_0000, 1'b1);
		// odd count, mean below median
		offer_sample(32'h8000_0000, 1'b0);
		offer_sample(32'h0001_0000, 1'b0);
		offer_sample(32'h0002_0000, 1'b1);
		// full set of maxima plus a dropped marked sample
		for (int i = 0; i < MAX_SAMPLES; i++)
			offer_sample(32'h7fff_ffff, 1'b0);
		offer_sample(32'h8000_0000, 1'b1);
		drain_scores();

		while (n_items < 500) begin
			if (n_items >= 340) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (n_items >= 170) begin
				tx_idle_pct = 52;
				rx_idle_pct = 36;
			end
			case ($urandom_range(9))
				0: set_len = MAX_SAMPLES;
				1: set_len = MAX_SAMPLES + $urandom_range(1, 4);
				2: set_len = 1;
				default: set_len = $urandom_range(2, MAX_SAMPLES - 1);
			endcase
			for (int i = 1; i <= set_len; i++)
				offer_sample(pick_sample(), i == set_len);
			// hold off now and then until every score is back
			if ($urandom_range(7) == 0)
				drain_scores();
		end

		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (waiting != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		$display("%0d samples in %0d sets, %0d scores checked, %0d sets with dropped samples",
			n_items, n_sets, n_scored, n_overflow);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
design/mmm_pkg.sv
design/mmm_if.sv
design/mmm_cell.sv
design/mmm_div.sv
design/min_of_median_and_mean.sv
tb/sv/min_of_median_and_mean_chk.sv
tb/sv/min_of_median_and_mean_tb.sv
